// File: rtl/core/aes128_block_encrypt_unit_macros.svh
// Assertion macros used by the RTL of the round cell.
`ifndef AES128_BLOCK_ENCRYPT_UNIT_MACROS_SVH
`define AES128_BLOCK_ENCRYPT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define AES_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define AES_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define AES_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define AES_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/core/aes_pkg.sv
package aes_pkg;

  localparam int unsigned BlockW = 128;
  localparam int unsigned CfgW   = 64;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned NumRounds = 10;

  localparam logic [CfgIdxW-1:0] RegKeyHigh = 2'd0;
  localparam logic [CfgIdxW-1:0] RegKeyLow  = 2'd1;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

// File: rtl/core/aes_round_cell.sv
`include "aes128_block_encrypt_unit_macros.svh"

module aes_round_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [aes_pkg::BlockW-1:0]   state_i,
  input  logic [aes_pkg::BlockW-1:0]   key_i,
  input  logic [7:0]                   rcon_i,
  input  logic                         final_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [aes_pkg::BlockW-1:0]   state_o,
  output logic [aes_pkg::BlockW-1:0]   key_o
);
  import aes_pkg::*;

  logic                valid_q;
  logic [BlockW-1:0]   state_q, state_d;
  logic [BlockW-1:0]   key_q, key_d;
  logic [7:0]          sb [16];
  logic [7:0]          mx [16];
  logic [31:0]         t_w, n0, n1, n2, n3;

  always_comb begin
    t_w = sub_word({key_i[23:0], key_i[31:24]}) ^ {rcon_i, 24'h0};
    n0 = key_i[127:96] ^ t_w;
    n1 = key_i[95:64] ^ n0;
    n2 = key_i[63:32] ^ n1;
    n3 = key_i[31:0] ^ n2;
    key_d = {n0, n1, n2, n3};
  end

  always_comb begin
    logic [7:0] all_x;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[4*c+r] = SBOX[state_i[BlockW-1-8*(4*((c+r)%4)+r) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      all_x = sb[4*c] ^ sb[4*c+1] ^ sb[4*c+2] ^ sb[4*c+3];
      for (int r = 0; r < 4; r++) begin
        mx[4*c+r] = sb[4*c+r] ^ all_x ^ xtime(sb[4*c+r] ^ sb[4*c+((r+1)%4)]);
      end
    end
    for (int k = 0; k < 16; k++) begin
      state_d[BlockW-1-8*k -: 8] = (final_i ? sb[k] : mx[k]) ^ key_d[BlockW-1-8*k -: 8];
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      state_q <= state_d;
      key_q   <= key_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign key_o   = key_q;

  `AES_ASSERT_IMP(a_empty_ready, clk_i, rst_ni, !valid_q, ready_o, "empty cell not ready")
  `AES_ASSERT_NXT(a_load_valid, clk_i, rst_ni, valid_i && ready_o, valid_q, "transfer lost")
  `AES_ASSERT_NXT(a_hold_state, clk_i, rst_ni, valid_q && !ready_i,
                  valid_q && $stable(state_q) && $stable(key_q), "stalled cell changed")

endmodule

// File: rtl/core/aes128_block_encrypt_unit.sv
// AES-128 ECB encryption, one 128-bit block per transfer.
// Input stream: s_axis_tdata carries block_high in bits 63:0 and block_low in
// bits 127:64. Output stream: m_axis_tdata carries cipher_high in bits 63:0
// and cipher_low in bits 127:64. Bytes are in FIPS order within each half.
// The key is written through cfg_we_i, cfg_index_i and cfg_data_i: index 0 is
// key_high, index 1 is key_low, other indexes are ignored. The key travels
// with each block, and each round cell derives its round key from the one
// before, so a new key applies to the very next block.
// The pipeline holds one AddRoundKey stage and ten round cells.
// Throughput is one block per cycle while the receiver does not stall.
// When the receiver stalls, the cells fill up one by one; each cell still
// accepts while it is empty, so bubbles close up before input stalls.
// Reset clears both key registers to zero and empties all stages.
module aes128_block_encrypt_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [aes_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [aes_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // block_high [63:0], block_low [127:64]
  input  logic [aes_pkg::BlockW-1:0]    s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // cipher_high [63:0], cipher_low [127:64]
  output logic [aes_pkg::BlockW-1:0]    m_axis_tdata
);
  import aes_pkg::*;

  logic [CfgW-1:0]   key_high_q, key_low_q;
  logic              v0_q;
  logic [BlockW-1:0] st0_q, key0_q;
  logic              valid_c [NumRounds+1];
  logic              ready_c [NumRounds+1];
  logic [BlockW-1:0] state_c [NumRounds+1];
  logic [BlockW-1:0] key_c   [NumRounds+1];
  logic [BlockW-1:0] key_cat, blk_cat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegKeyHigh: key_high_q <= cfg_data_i;
        RegKeyLow:  key_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign key_cat = {key_high_q, key_low_q};
  assign blk_cat = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
  assign s_axis_tready = !v0_q || ready_c[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (s_axis_tready) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      st0_q  <= blk_cat ^ key_cat;
      key0_q <= key_cat;
    end
  end

  assign valid_c[0] = v0_q;
  assign state_c[0] = st0_q;
  assign key_c[0]   = key0_q;
  assign ready_c[NumRounds] = m_axis_tready;

  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    aes_round_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[r]),
      .ready_o (ready_c[r]),
      .state_i (state_c[r]),
      .key_i   (key_c[r]),
      .rcon_i  (RCON[r]),
      .final_i (r == NumRounds - 1),
      .valid_o (valid_c[r+1]),
      .ready_i (ready_c[r+1]),
      .state_o (state_c[r+1]),
      .key_o   (key_c[r+1])
    );
  end

  assign m_axis_tvalid = valid_c[NumRounds];
  assign m_axis_tdata  = {state_c[NumRounds][63:0], state_c[NumRounds][127:64]};

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [aes_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [aes_pkg::CfgW-1:0]    cfg_data_i;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  // block_high [63:0], block_low [127:64]
  logic [aes_pkg::BlockW-1:0]  s_axis_tdata;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  // cipher_high [63:0], cipher_low [127:64]
  logic [aes_pkg::BlockW-1:0]  m_axis_tdata;

  localparam logic [aes_pkg::CfgIdxW-1:0] RegUnused2 = 2'd2;
  localparam logic [aes_pkg::CfgIdxW-1:0] RegUnused3 = 2'd3;
  localparam int unsigned PipeDepth = 11;

  aes128_block_encrypt_unit DUT (.*);

  logic [63:0]  key_hi_q, key_lo_q;
  logic [31:0]  key_words [44];
  logic [127:0] cipher_fifo [$];
  int           fail_count;
  bit           stall_free;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [7:0] gf_double(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic void schedule_keys();
    logic [31:0] t;
    logic [7:0]  rc;
    key_words[0] = key_hi_q[63:32];
    key_words[1] = key_hi_q[31:0];
    key_words[2] = key_lo_q[63:32];
    key_words[3] = key_lo_q[31:0];
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      t = key_words[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {aes_pkg::SBOX[t[31:24]], aes_pkg::SBOX[t[23:16]],
             aes_pkg::SBOX[t[15:8]], aes_pkg::SBOX[t[7:0]]} ^ {rc, 24'h0};
        rc = gf_double(rc);
      end
      key_words[i] = key_words[i-4] ^ t;
    end
  endfunction

  function automatic logic [127:0] encrypt_block(input logic [63:0] hi, input logic [63:0] lo);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] st;
    st = {hi, lo};
    for (int i = 0; i < 16; i++) s[i] = st[127-8*i -: 8];
    for (int r = 0; r <= 10; r++) begin
      if (r > 0) begin
        for (int c = 0; c < 4; c++)
          for (int k = 0; k < 4; k++) t[4*c+k] = aes_pkg::SBOX[s[4*((c+k)%4)+k]];
        s = t;
        if (r < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            s[4*c]   = a0 ^ all ^ gf_double(a0 ^ a1);
            s[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
            s[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
            s[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int k = 0; k < 4; k++) s[4*c+k] ^= key_words[4*r+c][31-8*k -: 8];
    end
    for (int i = 0; i < 16; i++) st[127-8*i -: 8] = s[i];
    return {st[63:0], st[127:64]};
  endfunction

  task automatic write_reg(input logic [aes_pkg::CfgIdxW-1:0] idx, input logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == aes_pkg::RegKeyHigh) key_hi_q = val;
    if (idx == aes_pkg::RegKeyLow) key_lo_q = val;
    schedule_keys();
  endtask

  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
    while (!stall_free && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {lo, hi};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    cipher_fifo.push_back(encrypt_block(hi, lo));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (cipher_fifo.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 4) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_reset_key();
    send_block('0, '0);
    send_block('1, '1);
    drain();
  endtask

  task automatic test_fips_vectors();
    write_reg(aes_pkg::RegKeyHigh, 64'h0001020304050607);
    write_reg(aes_pkg::RegKeyLow,  64'h08090a0b0c0d0e0f);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    drain();
    write_reg(aes_pkg::RegKeyHigh, 64'h2b7e151628aed2a6);
    write_reg(aes_pkg::RegKeyLow,  64'habf7158809cf4f3c);
    send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734);
    drain();
  endtask

  task automatic test_key_extremes();
    write_reg(aes_pkg::RegKeyHigh, '1);
    write_reg(aes_pkg::RegKeyLow,  '1);
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h8000000000000000, 64'h0000000000000001);
    drain();
    write_reg(RegUnused2, rand64());
    write_reg(RegUnused3, rand64());
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
    drain();
    write_reg(aes_pkg::RegKeyLow, '0);
    send_block('1, '0);
    drain();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(aes_pkg::RegKeyHigh, rand64());
      write_reg(aes_pkg::RegKeyLow, rand64());
      stall_free = (phase == 3);
      for (int n = 0; n < 106; n++) begin
        if (n == 50) drain();
        send_block(rand64(), rand64());
      end
      stall_free = 1'b0;
      drain();
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready <= stall_free || ($urandom_range(99) >= 17);
  end

  always @(posedge clk_i) begin
    logic [127:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cipher_fifo.size() == 0) begin
        $display("%0t: unexpected output, expected none, actual %h", $time, m_axis_tdata);
        fail_count++;
      end else begin
        want = cipher_fifo.pop_front();
        if (m_axis_tdata[63:0] !== want[63:0]) begin
          $display("%0t: cipher_high expected %h actual %h", $time, want[63:0],
                   m_axis_tdata[63:0]);
          fail_count++;
        end
        if (m_axis_tdata[127:64] !== want[127:64]) begin
          $display("%0t: cipher_low expected %h actual %h", $time, want[127:64],
                   m_axis_tdata[127:64]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    fail_count    = 0;
    stall_free    = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = aes_pkg::RegKeyHigh;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    key_hi_q      = '0;
    key_lo_q      = '0;
    schedule_keys();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_key();
    test_fips_vectors();
    test_key_extremes();
    test_random_traffic();
    if (cipher_fifo.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: aes128_block_encrypt_unit.f
+incdir+rtl/core
rtl/core/aes_pkg.sv
rtl/core/aes_round_cell.sv
rtl/core/aes128_block_encrypt_unit.sv
test/tb_top.sv
